// File: hdl/sra_pkg.sv
package sra_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 32;
  localparam int unsigned COL_W = 31;
  localparam int unsigned VAL_W = 64;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_FLUSH  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    STATUS_EMIT  = 2'd0,
    STATUS_DROP  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_FLUSH = 1'b1
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP    = 2'd2
  } cell_op_t;

  typedef struct packed {
    logic                    req_type;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]              status;
    logic [COL_W-1:0]        out_column;
    logic signed [VAL_W-1:0] out_value;
    logic                    last;
  } out_item_t;

  // Broadcast to every cell of the chain
  typedef struct packed {
    cell_op_t                op;
    logic                    new_entry;
    logic [COL_W-1:0]        column;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  function automatic logic signed [VAL_W-1:0] sat_add(
    input logic signed [VAL_W-1:0] a,
    input logic signed [VAL_W-1:0] b
  );
    logic signed [VAL_W-1:0] s;
    s = a + b;
    if ((a[VAL_W-1] == b[VAL_W-1]) && (s[VAL_W-1] != a[VAL_W-1])) begin
      s = a[VAL_W-1] ? VAL_MIN : VAL_MAX;
    end
    return s;
  endfunction

endpackage

// File: hdl/sra_cell.sv
module sra_cell (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sra_pkg::cell_ctrl_t               ctrl,
  input  logic                              left_lt,
  input  logic                              left_valid,
  input  logic [sra_pkg::COL_W-1:0]         left_column,
  input  logic signed [sra_pkg::VAL_W-1:0]  left_sum,
  input  logic                              right_valid,
  input  logic [sra_pkg::COL_W-1:0]         right_column,
  input  logic signed [sra_pkg::VAL_W-1:0]  right_sum,
  output logic                              valid,
  output logic [sra_pkg::COL_W-1:0]         column,
  output logic signed [sra_pkg::VAL_W-1:0]  sum,
  output logic                              lt,
  output logic                              eq
);

  logic                             valid_r, valid_nxt;
  logic [sra_pkg::COL_W-1:0]        column_r, column_nxt;
  logic signed [sra_pkg::VAL_W-1:0] sum_r, sum_nxt;

  // Compare held key against the broadcast column
  assign lt = valid_r && (column_r < ctrl.column);
  assign eq = valid_r && (column_r == ctrl.column);

  assign valid  = valid_r;
  assign column = column_r;
  assign sum    = sum_r;

  // Merge, place, shift right on insert; shift left on pop
  always_comb begin
    valid_nxt  = valid_r;
    column_nxt = column_r;
    sum_nxt    = sum_r;
    case (ctrl.op)
      sra_pkg::CELL_INSERT: begin
        if (eq) begin
          sum_nxt = sra_pkg::sat_add(sum_r, ctrl.value);
        end else if (ctrl.new_entry && !lt) begin
          if (left_lt) begin
            valid_nxt  = 1'b1;
            column_nxt = ctrl.column;
            sum_nxt    = ctrl.value;
          end else begin
            valid_nxt  = left_valid;
            column_nxt = left_column;
            sum_nxt    = left_sum;
          end
        end
      end
      sra_pkg::CELL_POP: begin
        valid_nxt  = right_valid;
        column_nxt = right_column;
        sum_nxt    = right_sum;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    column_r <= column_nxt;
    sum_r    <= sum_nxt;
  end

endmodule

// File: hdl/sorted_row_accumulator.sv
// Insert: a dropped insert shows its result the next cycle.
// Flush: held entries leave the head of the cell chain one per cycle while out_ready is
// high, the first the cycle after acceptance; input waits until the flush ends.
// Throughput: one insert per cycle while idle and the output register is free.
// Reset (rst_n low, synchronous): empties the row and the output register;
// held columns and sums are not cleared.
module sorted_row_accumulator #(
  parameter int unsigned MAX_ENTRIES = sra_pkg::MAX_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sra_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sra_pkg::out_item_t  out_data
);

  localparam int unsigned N = MAX_ENTRIES;

  logic                             cell_valid [N];
  logic [sra_pkg::COL_W-1:0]        cell_column [N];
  logic signed [sra_pkg::VAL_W-1:0] cell_sum [N];
  logic [N-1:0]                     cell_lt;
  logic [N-1:0]                     cell_eq;

  sra_pkg::cell_ctrl_t ctrl;
  sra_pkg::state_t     state_r, state_nxt;
  sra_pkg::out_item_t  out_r, out_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic out_free;
  logic in_fire;
  logic is_flush;
  logic any_eq;
  logic full;
  logic pop;
  logic drop;
  logic empty_flush;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == sra_pkg::ST_IDLE) && out_free;
  assign in_fire   = in_valid && in_ready;
  assign is_flush  = (in_data.req_type == sra_pkg::REQ_FLUSH);
  assign any_eq    = |cell_eq;
  assign full      = cell_valid[N-1];

  assign drop        = in_fire && !is_flush && !any_eq && full;
  assign empty_flush = in_fire && is_flush && !cell_valid[0];
  assign pop         = (in_fire && is_flush && cell_valid[0]) ||
                       ((state_r == sra_pkg::ST_FLUSH) && out_free);

  // Broadcast the operation to the chain
  always_comb begin
    ctrl.column    = in_data.column;
    ctrl.value     = in_data.entry_value;
    ctrl.new_entry = !any_eq && !full;
    if (pop) begin
      ctrl.op = sra_pkg::CELL_POP;
    end else if (in_fire && !is_flush) begin
      ctrl.op = sra_pkg::CELL_INSERT;
    end else begin
      ctrl.op = sra_pkg::CELL_HOLD;
    end
  end

  // Row of cells: head at index 0, sorted ascending
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic                             l_lt;
    logic                             l_valid;
    logic [sra_pkg::COL_W-1:0]        l_column;
    logic signed [sra_pkg::VAL_W-1:0] l_sum;
    logic                             r_valid;
    logic [sra_pkg::COL_W-1:0]        r_column;
    logic signed [sra_pkg::VAL_W-1:0] r_sum;

    if (i == 0) begin : g_head
      assign l_lt     = 1'b1;
      assign l_valid  = 1'b0;
      assign l_column = '0;
      assign l_sum    = '0;
    end else begin : g_body
      assign l_lt     = cell_lt[i-1];
      assign l_valid  = cell_valid[i-1];
      assign l_column = cell_column[i-1];
      assign l_sum    = cell_sum[i-1];
    end

    if (i == N - 1) begin : g_tail
      assign r_valid  = 1'b0;
      assign r_column = '0;
      assign r_sum    = '0;
    end else begin : g_mid
      assign r_valid  = cell_valid[i+1];
      assign r_column = cell_column[i+1];
      assign r_sum    = cell_sum[i+1];
    end

    sra_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .left_lt      (l_lt),
      .left_valid   (l_valid),
      .left_column  (l_column),
      .left_sum     (l_sum),
      .right_valid  (r_valid),
      .right_column (r_column),
      .right_sum    (r_sum),
      .valid        (cell_valid[i]),
      .column       (cell_column[i]),
      .sum          (cell_sum[i]),
      .lt           (cell_lt[i]),
      .eq           (cell_eq[i])
    );
  end

  // Flush sequencer and output register load
  always_comb begin
    state_nxt     = state_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      sra_pkg::ST_IDLE: begin
        if (pop && cell_valid[1]) begin
          state_nxt = sra_pkg::ST_FLUSH;
        end
      end
      sra_pkg::ST_FLUSH: begin
        if (pop && !cell_valid[1]) begin
          state_nxt = sra_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sra_pkg::ST_IDLE;
      end
    endcase

    if (pop) begin
      out_nxt.status     = sra_pkg::STATUS_EMIT;
      out_nxt.out_column = cell_column[0];
      out_nxt.out_value  = cell_sum[0];
      out_nxt.last       = !cell_valid[1];
      out_valid_nxt      = 1'b1;
    end else if (drop) begin
      out_nxt.status     = sra_pkg::STATUS_DROP;
      out_nxt.out_column = in_data.column;
      out_nxt.out_value  = in_data.entry_value;
      out_nxt.last       = 1'b0;
      out_valid_nxt      = 1'b1;
    end else if (empty_flush) begin
      out_nxt.status     = sra_pkg::STATUS_EMPTY;
      out_nxt.out_column = '0;
      out_nxt.out_value  = '0;
      out_nxt.last       = 1'b1;
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sra_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
